@@ src/spsa_pkg.sv @@
package spsa_pkg;

    // Score store geometry
    localparam int NODES   = 4096;
    localparam int NODE_W  = $clog2(NODES);
    // Node sums and limits: 16-bit base plus 16-bit offset
    localparam int SUM_W   = 17;

    // Field widths fixed by the interface
    localparam int BASE_W  = 16;
    localparam int FMT_W   = 2;
    localparam int MUL_W   = 32;
    localparam int CNT_W   = 13;
    localparam int OFS_W   = 16;
    localparam int WGT_W   = 32;
    localparam int RIDX_W  = 12;
    localparam int SCORE_W = 64;
    localparam int POST_W  = 64;

    // Operation codes (carried in s_tuser)
    localparam logic OP_ACC  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Weight formats; the unused code falls back to eight-bit
    localparam logic [FMT_W-1:0] FMT_FLOAT = 2'd0;
    localparam logic [FMT_W-1:0] FMT_INT8  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_INT16 = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_BASE_NODE     = 2'd0;
    localparam logic [1:0] REG_WEIGHT_FORMAT = 2'd1;
    localparam logic [1:0] REG_TERM_MUL      = 2'd2;
    localparam logic [1:0] REG_NODE_COUNT    = 2'd3;

    // Register reset values
    localparam logic [BASE_W-1:0] RST_BASE_NODE     = '0;
    localparam logic [FMT_W-1:0]  RST_WEIGHT_FORMAT = FMT_INT8;
    localparam logic [MUL_W-1:0]  RST_TERM_MUL      = 32'h0100_0000;
    localparam logic [CNT_W-1:0]  RST_NODE_COUNT    = 13'd4096;

    typedef struct packed {
        logic [BASE_W-1:0]       base_node;
        logic [FMT_W-1:0]        weight_format;
        logic signed [MUL_W-1:0] term_mul;
        logic [CNT_W-1:0]        node_count;
    } cfg_t;

    typedef struct packed {
        logic              operation;
        logic [OFS_W-1:0]  posting_offset;
        logic [WGT_W-1:0]  weight_bits;
        logic [RIDX_W-1:0] read_index;
    } item_t;

    // Controller to datapath
    typedef struct packed {
        logic clr;   // write one zero entry of the clearing pass
        logic cap;   // capture an accepted request
        logic fin;   // commit the write-back and load the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

@@ src/spsa_ctrl.sv @@
module spsa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  spsa_pkg::sts_t  sts,
    output spsa_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_ADD   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                // hold until the output register can take the result
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign cmd.clr  = (state_reg == ST_CLEAR);
    assign cmd.cap  = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.fin  = (state_reg == ST_ADD) && sts.out_free;

endmodule

@@ src/spsa_dpath.sv @@
module spsa_dpath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  spsa_pkg::cfg_t                        cfg,
    input  spsa_pkg::item_t                       item,
    input  spsa_pkg::cmd_t                        cmd,
    output spsa_pkg::sts_t                        sts,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_in_range,
    output logic signed [spsa_pkg::SCORE_W-1:0]   out_score,
    output logic [spsa_pkg::POST_W-1:0]           out_postings
);

    // IEEE single to signed Q16.16, truncated, saturated; NaN and subnormals give 0
    function automatic logic signed [31:0] float_to_q16(input logic [31:0] b);
        logic        neg;
        logic        zero;
        logic [7:0]  e;
        logic [7:0]  sh;
        logic [31:0] m;
        logic [31:0] mag;
        neg  = b[31];
        e    = b[30:23];
        m    = {8'b0, 1'b1, b[22:0]};
        zero = 1'b0;
        mag  = '0;
        if (e == 8'hFF) begin
            zero = (b[22:0] != 23'd0);
            mag  = 32'hFFFF_FFFF;
        end else if (e == 8'd0) begin
            zero = 1'b1;
        end else if (e >= 8'd134) begin
            sh  = e - 8'd134;
            mag = (sh > 8'd8) ? 32'hFFFF_FFFF : (m << sh[3:0]);
        end else begin
            sh  = 8'd134 - e;
            mag = (sh >= 8'd24) ? 32'd0 : (m >> sh[4:0]);
        end
        if (neg) begin
            if (mag > 32'h8000_0000) mag = 32'h8000_0000;
            mag = -mag;
        end else begin
            if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
        end
        return zero ? 32'sd0 : $signed(mag);
    endfunction

    localparam int NW = spsa_pkg::NODE_W;
    localparam int SW = spsa_pkg::SUM_W;
    localparam int DW = spsa_pkg::SCORE_W;

    logic signed [DW-1:0] mem [spsa_pkg::NODES];

    logic [NW-1:0]              clr_addr_reg;
    logic [spsa_pkg::POST_W-1:0] post_cnt_reg;
    logic                        out_valid_reg;

    logic                 op_reg;
    logic                 inr_reg;
    logic                 flt_reg;
    logic [NW-1:0]        addr_reg;
    logic signed [31:0]   op_a_reg;
    logic signed [31:0]   op_b_reg;
    logic signed [DW-1:0] prod_reg;
    logic signed [DW-1:0] rd_data_reg;

    logic                                out_inr_reg;
    logic signed [DW-1:0]                out_score_reg;
    logic [spsa_pkg::POST_W-1:0]         out_post_reg;

    logic [SW-1:0]        lim;
    logic [SW-1:0]        node;
    logic                 inr_next;
    logic [NW-1:0]        addr_next;
    logic signed [31:0]   op_b_next;
    logic signed [DW-1:0] prod_next;
    logic signed [DW-1:0] inc;
    logic [DW:0]          sum_wide;
    logic signed [DW-1:0] sum;
    logic signed [DW-1:0] score_next;
    logic                 mem_we;
    logic [NW-1:0]        mem_wa;
    logic signed [DW-1:0] mem_wd;

    // Node limit is the smaller of node_count and the store depth
    assign lim  = (SW'(cfg.node_count) < SW'(spsa_pkg::NODES))
                ? SW'(cfg.node_count) : SW'(spsa_pkg::NODES);
    assign node = SW'(cfg.base_node) + SW'(item.posting_offset);

    always_comb begin
        if (item.operation == spsa_pkg::OP_ACC) begin
            inr_next  = (node < lim);
            addr_next = node[NW-1:0];
        end else begin
            inr_next  = (SW'(item.read_index) < lim);
            addr_next = NW'(item.read_index);
        end
        priority if (cfg.weight_format == spsa_pkg::FMT_FLOAT) begin
            op_b_next = float_to_q16(item.weight_bits);
        end else if (cfg.weight_format == spsa_pkg::FMT_INT16) begin
            op_b_next = $signed({16'b0, item.weight_bits[15:0]});
        end else begin
            op_b_next = $signed({24'b0, item.weight_bits[7:0]});
        end
    end

    assign prod_next = DW'(op_a_reg) * DW'(op_b_reg);

    // Float product is Q.40: arithmetic shift drops to Q.24 with floor rounding
    assign inc = flt_reg ? {{16{prod_reg[DW-1]}}, prod_reg[DW-1:16]} : prod_reg;

    assign sum_wide = {rd_data_reg[DW-1], rd_data_reg} + {inc[DW-1], inc};
    always_comb begin
        if (sum_wide[DW] != sum_wide[DW-1]) begin
            sum = sum_wide[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            sum = sum_wide[DW-1:0];
        end
    end

    assign score_next = !inr_reg ? '0 : ((op_reg == spsa_pkg::OP_ACC) ? sum : rd_data_reg);

    assign mem_we = cmd.clr || (cmd.fin && (op_reg == spsa_pkg::OP_ACC) && inr_reg);
    assign mem_wa = cmd.clr ? clr_addr_reg : addr_reg;
    assign mem_wd = cmd.clr ? '0 : sum;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            post_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr) clr_addr_reg <= clr_addr_reg + NW'(1);
            if (cmd.cap && (item.operation == spsa_pkg::OP_ACC)) begin
                post_cnt_reg <= post_cnt_reg + spsa_pkg::POST_W'(1);
            end
            if (cmd.fin) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            op_reg   <= item.operation;
            inr_reg  <= inr_next;
            flt_reg  <= (cfg.weight_format == spsa_pkg::FMT_FLOAT);
            addr_reg <= addr_next;
            op_a_reg <= cfg.term_mul;
            op_b_reg <= op_b_next;
        end
        prod_reg <= prod_next;
        if (cmd.fin) begin
            out_inr_reg   <= inr_reg;
            out_score_reg <= score_next;
            out_post_reg  <= post_cnt_reg;
        end
    end

    assign sts.clr_last = (clr_addr_reg == NW'(spsa_pkg::NODES - 1));
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_in_range = out_inr_reg;
    assign out_score    = out_score_reg;
    assign out_postings = out_post_reg;

endmodule

@@ src/sparse_posting_score_accumulator.sv @@
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------------------
// s_       | in        | s_tvalid/s_tready  | tuser operation; tdata offset, weight, index
// m_       | out       | m_tvalid/m_tready  | tuser in_range; tdata score, postings_seen
// apb      | in        | psel/penable       | base_node, weight_format, term_mul, node_count
//
// Every request passes through the block in steps: capture at acceptance, multiply and
// store read, then saturating add and write-back; its result enters the output register
// at the end of the add step. The single read-modify-write on the score store means a new
// request is taken only after the previous result is loaded. After reset a clearing pass
// zeroes the store with s_tready low. A request waits in its final step while the output
// register is full and m_tready is low; s_tready rises again once the result is loaded.
module sparse_posting_score_accumulator (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [15:0] posting_offset, [47:16] weight_bits,
                                    // [59:48] read_index, [63:60] zero
    input  logic [0:0]   s_tuser,   // [0] operation

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] score_value, [127:64] postings_seen
    output logic [0:0]   m_tuser,   // [0] in_range

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [spsa_pkg::BASE_W-1:0] base_node_reg;
    logic [spsa_pkg::FMT_W-1:0]  weight_format_reg;
    logic [spsa_pkg::MUL_W-1:0]  term_mul_reg;
    logic [spsa_pkg::CNT_W-1:0]  node_count_reg;

    logic       cfg_we;
    logic [1:0] reg_idx;

    spsa_pkg::cfg_t  cfg;
    spsa_pkg::item_t item;
    spsa_pkg::cmd_t  cmd;
    spsa_pkg::sts_t  sts;

    logic                                out_in_range;
    logic signed [spsa_pkg::SCORE_W-1:0] out_score;
    logic [spsa_pkg::POST_W-1:0]         out_postings;

    // Register file: write on the access phase, decode by word address
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_node_reg     <= spsa_pkg::RST_BASE_NODE;
            weight_format_reg <= spsa_pkg::RST_WEIGHT_FORMAT;
            term_mul_reg      <= spsa_pkg::RST_TERM_MUL;
            node_count_reg    <= spsa_pkg::RST_NODE_COUNT;
        end else if (cfg_we) begin
            unique case (reg_idx)
                spsa_pkg::REG_BASE_NODE:     base_node_reg     <= pwdata[15:0];
                spsa_pkg::REG_WEIGHT_FORMAT: weight_format_reg <= pwdata[1:0];
                spsa_pkg::REG_TERM_MUL:      term_mul_reg      <= pwdata;
                spsa_pkg::REG_NODE_COUNT:    node_count_reg    <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register, zero-extended
    always_comb begin
        unique case (reg_idx)
            spsa_pkg::REG_BASE_NODE:     prdata = 32'(base_node_reg);
            spsa_pkg::REG_WEIGHT_FORMAT: prdata = 32'(weight_format_reg);
            spsa_pkg::REG_TERM_MUL:      prdata = term_mul_reg;
            spsa_pkg::REG_NODE_COUNT:    prdata = 32'(node_count_reg);
            default:                     prdata = '0;
        endcase
    end

    assign cfg.base_node     = base_node_reg;
    assign cfg.weight_format = weight_format_reg;
    assign cfg.term_mul      = $signed(term_mul_reg);
    assign cfg.node_count    = node_count_reg;

    // Unpack the input request
    assign item.operation      = s_tuser[0];
    assign item.posting_offset = s_tdata[15:0];
    assign item.weight_bits    = s_tdata[47:16];
    assign item.read_index     = s_tdata[59:48];

    spsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spsa_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_in_range (out_in_range),
        .out_score    (out_score),
        .out_postings (out_postings)
    );

    // Pack the result request
    assign m_tuser[0] = out_in_range;
    assign m_tdata    = {out_postings, out_score};

endmodule

@@ test/testbench.sv @@
module testbench;

    // Run length: stimulus per random phase and per test, the long hold-off and the watchdog bound
    localparam int RANDOM_PHASES    = 7;
    localparam int PHASE_ITEMS      = 230;
    localparam int HOLDOFF_ITEMS    = 60;
    localparam int STEADY_ITEMS     = 150;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 1_000_000;

    // One expected result as it leaves the m_ channel
    typedef struct {
        logic                                in_range;
        logic signed [spsa_pkg::SCORE_W-1:0] score;
        logic [spsa_pkg::POST_W-1:0]         postings;
    } score_result_t;

    logic         aclk;
    logic         aresetn  = 1'b0;

    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata  = '0;    // [15:0] posting_offset, [47:16] weight_bits,
                                    // [59:48] read_index, [63:60] zero
    logic [0:0]   s_tuser  = '0;    // [0] operation

    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;          // [63:0] score_value, [127:64] postings_seen
    logic [0:0]   m_tuser;          // [0] in_range

    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [3:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    // Mirror of the register file, updated at the write edge
    logic [spsa_pkg::BASE_W-1:0]       cfg_base   = spsa_pkg::RST_BASE_NODE;
    logic [spsa_pkg::FMT_W-1:0]        cfg_format = spsa_pkg::RST_WEIGHT_FORMAT;
    logic signed [spsa_pkg::MUL_W-1:0] cfg_term   = spsa_pkg::RST_TERM_MUL;
    logic [spsa_pkg::CNT_W-1:0]        cfg_count  = spsa_pkg::RST_NODE_COUNT;

    // Mirror of the score store and the posting counter
    logic signed [spsa_pkg::SCORE_W-1:0] node_scores [spsa_pkg::NODES];
    logic [spsa_pkg::POST_W-1:0]         posting_total = '0;
    score_result_t                       expected_scores[$];

    int          failures      = 0;
    bit          steady_flow   = 1'b0;  // no idling on either side while set
    bit          long_hold_req = 1'b0;  // ask the result sink for a long hold-off
    logic [spsa_pkg::OFS_W-1:0] hot_offset = '0;  // hot spot for back-to-back updates

    sparse_posting_score_accumulator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Score arithmetic
    // ------------------------------------------------------------------

    // Effective node limit: node_count clamps at the store depth
    function automatic int node_limit();
        return (cfg_count > spsa_pkg::NODES) ? spsa_pkg::NODES : int'(cfg_count);
    endfunction

    // IEEE single to signed Q16.16, truncated toward zero and saturated.
    // Subnormals and NaN give zero; infinities saturate by sign.
    function automatic logic signed [63:0] float_weight_q16(input logic [31:0] bits);
        logic [7:0]  ex;
        logic [63:0] mant;
        logic [63:0] mag;
        int          sh;
        ex = bits[30:23];
        if (ex == 8'hFF) begin
            if (bits[22:0] != 0)
                return 0;
            mag = 64'hFFFF_FFFF;
        end else if (ex == 8'h00) begin
            return 0;
        end else begin
            mant = {40'd0, 1'b1, bits[22:0]};
            sh   = int'(ex) - 134;
            if (sh >= 0)
                mag = (sh > 8) ? 64'hFFFF_FFFF : (mant << sh);
            else
                mag = (-sh >= 24) ? 64'd0 : (mant >> (-sh));
        end
        if (bits[31]) begin
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            return -$signed(mag);
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return $signed(mag);
    endfunction

    // 64-bit signed add that clamps on overflow
    function automatic logic signed [63:0] saturating_add(input logic signed [63:0] a,
                                                          input logic signed [63:0] b);
        logic [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum[64:63] == 2'b01)
            return {1'b0, {63{1'b1}}};
        if (sum[64:63] == 2'b10)
            return {1'b1, 63'd0};
        return sum[63:0];
    endfunction

    // Apply one accepted request to the mirrors and queue its result
    task automatic apply_request(input logic op, input logic [spsa_pkg::OFS_W-1:0] ofs,
                                 input logic [spsa_pkg::WGT_W-1:0] wgt,
                                 input logic [spsa_pkg::RIDX_W-1:0] idx);
        score_result_t               res;
        logic [spsa_pkg::SUM_W-1:0]  node;
        logic signed [63:0]          inc;
        int                          lim;
        lim          = node_limit();
        res.in_range = 1'b0;
        res.score    = '0;
        if (op == spsa_pkg::OP_ACC) begin
            node = spsa_pkg::SUM_W'(cfg_base) + spsa_pkg::SUM_W'(ofs);
            posting_total = posting_total + 1;
            if (node < lim) begin
                case (cfg_format)
                    spsa_pkg::FMT_FLOAT:
                        inc = (cfg_term * float_weight_q16(wgt)) >>> 16;
                    spsa_pkg::FMT_INT16:
                        inc = cfg_term * $signed({1'b0, wgt[15:0]});
                    default:
                        inc = cfg_term * $signed({1'b0, wgt[7:0]});
                endcase
                node_scores[node[spsa_pkg::NODE_W-1:0]] =
                    saturating_add(node_scores[node[spsa_pkg::NODE_W-1:0]], inc);
                res.in_range = 1'b1;
                res.score    = node_scores[node[spsa_pkg::NODE_W-1:0]];
            end
        end else if (idx < lim) begin
            res.in_range = 1'b1;
            res.score    = node_scores[idx];
        end
        res.postings = posting_total;
        expected_scores.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Idle length for either side: mostly none, some short, a few long
    function automatic int idle_length();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // APB write: setup, then access until pready; psel is dropped before the task returns, so
    // back-to-back calls never touch psel twice in one step.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            spsa_pkg::REG_BASE_NODE:     cfg_base   = value[spsa_pkg::BASE_W-1:0];
            spsa_pkg::REG_WEIGHT_FORMAT: cfg_format = value[spsa_pkg::FMT_W-1:0];
            spsa_pkg::REG_TERM_MUL:      cfg_term   = value;
            spsa_pkg::REG_NODE_COUNT:    cfg_count  = value[spsa_pkg::CNT_W-1:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one request; keep tvalid high across a zero gap so the next
    // request follows without a bubble.
    task automatic send_request(input logic op, input logic [spsa_pkg::OFS_W-1:0] ofs,
                                input logic [spsa_pkg::WGT_W-1:0] wgt,
                                input logic [spsa_pkg::RIDX_W-1:0] idx);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, idx, wgt, ofs};
        do @(posedge aclk); while (!s_tready);
        apply_request(op, ofs, wgt, idx);
        gap = idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Random request: mostly in-range postings, many on a few hot nodes to
    // hit back-to-back read-modify-write, the rest noise over the full fields.
    task automatic send_random_request();
        logic                        op;
        logic [spsa_pkg::OFS_W-1:0]  ofs;
        logic [spsa_pkg::WGT_W-1:0]  wgt;
        logic [spsa_pkg::RIDX_W-1:0] idx;
        int                          lim;
        int                          pick;
        lim  = node_limit();
        op   = ($urandom_range(0, 3) == 0) ? spsa_pkg::OP_READ : spsa_pkg::OP_ACC;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            ofs = hot_offset + spsa_pkg::OFS_W'($urandom_range(0, 3));
        else if (pick < 8 && cfg_base < lim)
            ofs = spsa_pkg::OFS_W'($urandom_range(0, lim - 1 - cfg_base));
        else
            ofs = spsa_pkg::OFS_W'($urandom);
        if (pick < 4)
            idx = spsa_pkg::RIDX_W'(cfg_base + ofs);
        else
            idx = spsa_pkg::RIDX_W'($urandom);
        // Float weights mostly near the Q16.16 range, some raw bit patterns
        if (cfg_format == spsa_pkg::FMT_FLOAT && $urandom_range(0, 7) != 0)
            wgt = {1'($urandom), 8'($urandom_range(100, 160)), 23'($urandom)};
        else
            wgt = $urandom;
        send_request(op, ofs, wgt, idx);
    endtask

    // Drop tvalid and wait until every queued result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_scores.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------

    // Drive m_tready: random stalls, or a long hold-off on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 3) == 0)
                    stall_left = idle_length();
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : check_results
        score_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_scores.size() == 0) begin
                $display("%0t: result with none expected: tuser=%0d tdata=%h",
                         $time, m_tuser, m_tdata);
                failures++;
            end else begin
                want = expected_scores.pop_front();
                if (m_tuser[0] !== want.in_range) begin
                    $display("%0t: in_range expected %0d, actual %0d",
                             $time, want.in_range, m_tuser[0]);
                    failures++;
                end
                if (m_tdata[63:0] !== want.score) begin
                    $display("%0t: score_value expected %0d, actual %0d",
                             $time, want.score, $signed(m_tdata[63:0]));
                    failures++;
                end
                if (m_tdata[127:64] !== want.postings) begin
                    $display("%0t: postings_seen expected %0d, actual %0d",
                             $time, want.postings, m_tdata[127:64]);
                    failures++;
                end
            end
        end
    end

    // Bound the run in cycles
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset configuration: eight-bit weights, unit multiplier, full store
    task automatic test_reset_defaults();
        send_request(spsa_pkg::OP_READ, 16'd0,    32'h0,         12'd0);
        send_request(spsa_pkg::OP_ACC,  16'd0,    32'hFFFF_FFFF, 12'd0);   // low byte only
        send_request(spsa_pkg::OP_ACC,  16'd0,    32'h0000_0001, 12'd0);   // same node again
        send_request(spsa_pkg::OP_ACC,  16'd4095, 32'h0000_0080, 12'd0);   // last node
        send_request(spsa_pkg::OP_ACC,  16'd4096, 32'h0000_0010, 12'd0);   // first past limit
        send_request(spsa_pkg::OP_ACC,  16'hFFFF, 32'h0000_0055, 12'hFFF); // largest offset
        send_request(spsa_pkg::OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF);
        wait_for_results();
    endtask

    // Float weights; the multiplier's low bits make the floor shift matter
    task automatic test_float_weights();
        write_register(spsa_pkg::REG_WEIGHT_FORMAT, 32'(spsa_pkg::FMT_FLOAT));
        write_register(spsa_pkg::REG_TERM_MUL,      32'h0100_0003);
        send_request(spsa_pkg::OP_ACC, 16'd1,  32'h3F80_0000, 12'd0);  // 1.0
        send_request(spsa_pkg::OP_ACC, 16'd2,  32'hBFC0_0000, 12'd0);  // -1.5, rounds down
        send_request(spsa_pkg::OP_ACC, 16'd3,  32'h7F80_0000, 12'd0);  // +inf saturates
        send_request(spsa_pkg::OP_ACC, 16'd4,  32'hFF80_0000, 12'd0);  // -inf saturates
        send_request(spsa_pkg::OP_ACC, 16'd5,  32'h7FC0_0000, 12'd0);  // NaN gives zero
        send_request(spsa_pkg::OP_ACC, 16'd6,  32'h0000_0001, 12'd0);  // subnormal gives zero
        send_request(spsa_pkg::OP_ACC, 16'd7,  32'h5015_02F9, 12'd0);  // huge positive
        send_request(spsa_pkg::OP_ACC, 16'd8,  32'hD015_02F9, 12'd0);  // huge negative
        send_request(spsa_pkg::OP_ACC, 16'd9,  32'h3586_37BD, 12'd0);  // truncates to zero
        send_request(spsa_pkg::OP_ACC, 16'd10, 32'hB780_0000, 12'd0);  // -2^-16
        wait_for_results();
    endtask

    // Sixteen-bit weights, the unused format code, multiplier extremes
    task automatic test_integer_formats();
        write_register(spsa_pkg::REG_WEIGHT_FORMAT, 32'(spsa_pkg::FMT_INT16));
        write_register(spsa_pkg::REG_TERM_MUL,      32'h8000_0000);
        send_request(spsa_pkg::OP_ACC, 16'd20, 32'h0000_FFFF, 12'd0);
        send_request(spsa_pkg::OP_ACC, 16'd20, 32'h1234_0000, 12'd0);  // upper half ignored
        wait_for_results();
        write_register(spsa_pkg::REG_WEIGHT_FORMAT, 32'd3);            // behaves as eight-bit
        write_register(spsa_pkg::REG_TERM_MUL,      32'h7FFF_FFFF);
        send_request(spsa_pkg::OP_ACC, 16'd21, 32'h0000_ABCD, 12'd0);
        wait_for_results();
        write_register(spsa_pkg::REG_TERM_MUL, 32'h0);
        send_request(spsa_pkg::OP_ACC, 16'd22, 32'h0000_00FF, 12'd0);
        wait_for_results();
    endtask

    // Base plus offset past 16 bits, node_count below, at and above the store depth
    task automatic test_node_limits();
        write_register(spsa_pkg::REG_TERM_MUL,  32'h0100_0000);
        write_register(spsa_pkg::REG_BASE_NODE, 32'h0000_FFFF);
        send_request(spsa_pkg::OP_ACC,  16'hFFFF, 32'h0000_0011, 12'd0); // sum past 16 bits
        send_request(spsa_pkg::OP_READ, 16'd0,    32'h0,         12'd5); // reads ignore base
        wait_for_results();
        write_register(spsa_pkg::REG_BASE_NODE, 32'd4000);
        send_request(spsa_pkg::OP_ACC, 16'd95, 32'h0000_0022, 12'd0);    // node 4095
        send_request(spsa_pkg::OP_ACC, 16'd96, 32'h0000_0033, 12'd0);    // node 4096
        wait_for_results();
        write_register(spsa_pkg::REG_NODE_COUNT, 32'hFFFF_E064);         // low 13 bits: 100
        send_request(spsa_pkg::OP_READ, 16'd0, 32'h0, 12'd99);
        send_request(spsa_pkg::OP_READ, 16'd0, 32'h0, 12'd100);
        wait_for_results();
        write_register(spsa_pkg::REG_NODE_COUNT, 32'd0);
        send_request(spsa_pkg::OP_READ, 16'd0, 32'h0,         12'd0);
        send_request(spsa_pkg::OP_ACC,  16'd0, 32'h0000_0044, 12'd0);
        wait_for_results();
        write_register(spsa_pkg::REG_NODE_COUNT, 32'd8191);              // clamps at the depth
        send_request(spsa_pkg::OP_READ, 16'd0, 32'h0, 12'd4095);
        wait_for_results();
    endtask

    // Random phases, each with its own register setting; the first few pin
    // the extremes, the rest are drawn at random
    task automatic test_random_traffic();
        logic [31:0] base_v;
        logic [31:0] fmt_v;
        logic [31:0] term_v;
        logic [31:0] count_v;
        int          lim;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    base_v  = 0;
                    fmt_v   = 32'(spsa_pkg::FMT_FLOAT);
                    term_v  = 32'h7FFF_FFFF;
                    count_v = 8191;
                end
                1: begin
                    base_v  = 0;
                    fmt_v   = 32'(spsa_pkg::FMT_INT16);
                    term_v  = 32'h8000_0000;
                    count_v = 1;
                end
                2: begin
                    base_v  = 4095;
                    fmt_v   = 3;
                    term_v  = 32'h0100_0000;
                    count_v = spsa_pkg::NODES;
                end
                default: begin
                    base_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 3000);
                    fmt_v  = $urandom_range(0, 3);
                    case ($urandom_range(0, 3))
                        0:       term_v = $urandom;
                        1:       term_v = 32'h0100_0000;
                        2:       term_v = $urandom_range(0, 1 << 25);
                        default: term_v = -$urandom_range(0, 1 << 25);
                    endcase
                    count_v = ($urandom_range(0, 1) == 0) ? spsa_pkg::NODES
                                                          : $urandom_range(0, 8191);
                end
            endcase
            write_register(spsa_pkg::REG_BASE_NODE,     base_v);
            write_register(spsa_pkg::REG_WEIGHT_FORMAT, fmt_v);
            write_register(spsa_pkg::REG_TERM_MUL,      term_v);
            write_register(spsa_pkg::REG_NODE_COUNT,    count_v);
            lim = node_limit();
            hot_offset = (cfg_base < lim)
                       ? spsa_pkg::OFS_W'($urandom_range(0, lim - 1 - cfg_base))
                       : spsa_pkg::OFS_W'($urandom);
            repeat (PHASE_ITEMS) send_random_request();
            wait_for_results();
        end
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // so the block fills and stalls its input
    task automatic test_output_backpressure();
        long_hold_req = 1'b1;
        repeat (HOLDOFF_ITEMS) send_random_request();
        wait_for_results();
    endtask

    // Full rate on both sides, no idling at all
    task automatic test_steady_stream();
        steady_flow = 1'b1;
        repeat (STEADY_ITEMS) send_random_request();
        wait_for_results();
        steady_flow = 1'b0;
    endtask

    initial begin
        foreach (node_scores[i])
            node_scores[i] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_float_weights();
        test_integer_formats();
        test_node_limits();
        test_random_traffic();
        test_output_backpressure();
        test_steady_stream();

        wait_for_results();
        repeat (10) @(posedge aclk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
